>>> rtl/dq_pkg.sv
`timescale 1ns / 1ps

package dq_pkg;

    // Ring geometry.
    localparam int DEPTH  = 256;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Fixed field widths of the transaction payloads.
    localparam int FUNC_W   = 3;
    localparam int DATA_W   = 32;
    localparam int INDEX_W  = 8;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 9;

    localparam logic [CNT_W:0] DEPTH_V = (CNT_W + 1)'(DEPTH);

    // Operation codes.
    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH_BACK  = 3'd0,
        FN_PUSH_FRONT = 3'd1,
        FN_POP_BACK   = 3'd2,
        FN_POP_FRONT  = 3'd3,
        FN_READ_IDX   = 3'd4,
        FN_WRITE_IDX  = 3'd5
    } func_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef struct packed {
        logic [FUNC_W-1:0]         func;
        logic signed [DATA_W-1:0]  value;
        logic [INDEX_W-1:0]        index;
    } item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]  data;
        logic [STATUS_W-1:0]       status;
        logic [COUNT_W-1:0]        count;
    } result_t;

    // At most one memory access per transaction.
    typedef struct packed {
        logic              en;
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] wdata;
    } mem_req_t;

    // What the result stage needs besides the read data.
    typedef struct packed {
        status_t           status;
        logic [CNT_W-1:0]  count;
        logic              use_rdata;
    } resp_info_t;

    // Ring slot at a given offset from a base slot; the sum stays below twice the depth.
    function automatic logic [ADDR_W-1:0] ring_add(logic [ADDR_W-1:0] base,
                                                   logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = {{(CNT_W + 1 - ADDR_W){1'b0}}, base} + {1'b0, off};
        if (sum >= DEPTH_V)
        begin
            sum = sum - DEPTH_V;
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

>>> rtl/dq_ram.sv
`timescale 1ns / 1ps

module dq_ram #(
    parameter int WORDS  = 256,
    parameter int ADDR_W = $clog2(WORDS),
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  logic              en,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [WORDS];
    logic [DATA_W-1:0] rdata_reg;

    // Single port: one write or one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/dq_ctrl.sv
`timescale 1ns / 1ps

module dq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  dq_pkg::item_t       item,
    output dq_pkg::mem_req_t    mem_req,
    output dq_pkg::resp_info_t  info
);

    import dq_pkg::*;

    logic [ADDR_W-1:0] front_reg;
    logic [ADDR_W-1:0] front_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    logic              is_full;
    logic              is_empty;
    logic [CNT_W-1:0]  index_ext;
    logic              index_ok;
    logic [ADDR_W-1:0] front_dec;
    logic [ADDR_W-1:0] front_inc;

    assign is_full   = (count_reg == CNT_W'(DEPTH));
    assign is_empty  = (count_reg == '0);
    assign index_ext = CNT_W'(item.index);
    assign index_ok  = (index_ext < count_reg);
    assign front_dec = (front_reg == '0) ? ADDR_W'(DEPTH - 1) : front_reg - 1'b1;
    assign front_inc = (front_reg == ADDR_W'(DEPTH - 1)) ? '0 : front_reg + 1'b1;

    // Decode the operation into at most one memory access and the new ring pointers.
    always_comb
    begin
        front_next        = front_reg;
        count_next        = count_reg;
        mem_req.en        = 1'b0;
        mem_req.we        = 1'b0;
        mem_req.addr      = front_reg;
        mem_req.wdata     = item.value;
        info.status       = ST_OK;
        info.use_rdata    = 1'b0;

        case (item.func)
            FN_PUSH_BACK:
            begin
                if (is_full)
                begin
                    info.status = ST_FULL;
                end
                else
                begin
                    mem_req.en   = 1'b1;
                    mem_req.we   = 1'b1;
                    mem_req.addr = ring_add(front_reg, count_reg);
                    count_next   = count_reg + 1'b1;
                end
            end
            FN_PUSH_FRONT:
            begin
                if (is_full)
                begin
                    info.status = ST_FULL;
                end
                else
                begin
                    mem_req.en   = 1'b1;
                    mem_req.we   = 1'b1;
                    mem_req.addr = front_dec;
                    front_next   = front_dec;
                    count_next   = count_reg + 1'b1;
                end
            end
            FN_POP_BACK:
            begin
                if (is_empty)
                begin
                    info.status = ST_EMPTY;
                end
                else
                begin
                    mem_req.en     = 1'b1;
                    mem_req.addr   = ring_add(front_reg, count_reg - 1'b1);
                    count_next     = count_reg - 1'b1;
                    info.use_rdata = 1'b1;
                end
            end
            FN_POP_FRONT:
            begin
                if (is_empty)
                begin
                    info.status = ST_EMPTY;
                end
                else
                begin
                    mem_req.en     = 1'b1;
                    mem_req.addr   = front_reg;
                    front_next     = front_inc;
                    count_next     = count_reg - 1'b1;
                    info.use_rdata = 1'b1;
                end
            end
            FN_READ_IDX:
            begin
                if (!index_ok)
                begin
                    info.status = ST_RANGE;
                end
                else
                begin
                    mem_req.en     = 1'b1;
                    mem_req.addr   = ring_add(front_reg, index_ext);
                    info.use_rdata = 1'b1;
                end
            end
            FN_WRITE_IDX:
            begin
                if (!index_ok)
                begin
                    info.status = ST_RANGE;
                end
                else
                begin
                    mem_req.en   = 1'b1;
                    mem_req.we   = 1'b1;
                    mem_req.addr = ring_add(front_reg, index_ext);
                end
            end
            default:
            begin
                info.status = ST_OK;
            end
        endcase

        // Nothing touches memory unless the transaction is taken.
        mem_req.en = mem_req.en & accept;
        info.count = count_next;
    end

    // Ring pointers advance only on accepted transactions.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
        end
        else if (accept)
        begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

endmodule

>>> rtl/double_ended_queue.sv
`timescale 1ns / 1ps

// Double-ended queue of signed 32-bit values kept as a ring in one memory.
// Input channel item/item_valid/item_stall carries one operation per
// transaction: push back, push front, pop back, pop front, read at an index
// from the front, or write at such an index. Every input transaction yields
// exactly one result transaction on result/result_valid/result_stall with
// data, status and the element count after the operation.
// An accepted transaction passes through the memory read stage and the
// output register before its result is offered. Throughput: one transaction
// per cycle while the receiver does not stall, set by the single memory port,
// which serves one read or one write per operation.
// Reset clears the ring pointers and the count, so the queue starts empty;
// the memory itself is not cleared, since only written entries are read.
// When the receiver stalls, the result is held in the output register and
// one more transaction can sit in the memory read stage; beyond that,
// item_stall rises in the same cycle until the output drains.

module double_ended_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  dq_pkg::item_t     item,
    output logic              result_valid,
    input  logic              result_stall,
    output dq_pkg::result_t   result
);

    import dq_pkg::*;

    logic        accept;
    logic        advance;
    mem_req_t    mem_req;
    resp_info_t  info;
    logic [DATA_W-1:0] rdata;

    logic        s1_valid_reg;
    logic        s1_valid_next;
    resp_info_t  s1_info_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    result_t     out_reg;

    // Handshake: the read stage moves on when the output register is free.
    assign advance    = s1_valid_reg && (!out_valid_reg || !result_stall);
    assign item_stall = s1_valid_reg && !advance;
    assign accept     = item_valid && !item_stall;

    dq_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .item    (item),
        .mem_req (mem_req),
        .info    (info)
    );

    dq_ram #(
        .WORDS  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (DATA_W)
    ) u_ram (
        .clk   (clk),
        .en    (mem_req.en),
        .we    (mem_req.we),
        .addr  (mem_req.addr),
        .wdata (mem_req.wdata),
        .rdata (rdata)
    );

    assign s1_valid_next  = accept || (s1_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && result_stall);

    // Valid flags of the read stage and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_info_reg <= info;
        end
        if (advance)
        begin
            out_reg.data   <= s1_info_reg.use_rdata ? rdata : '0;
            out_reg.status <= s1_info_reg.status;
            out_reg.count  <= COUNT_W'(s1_info_reg.count);
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // A waiting read result is never overwritten by a new memory read.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |-> !mem_req.en)
        else $error("memory accessed while read stage is held");

    // A full status only ever comes with a full queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.status == ST_FULL) |-> (result.count == COUNT_W'(DEPTH)))
        else $error("full status with queue not full");

    // An empty status only with an empty queue and zero data.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.status == ST_EMPTY) |-> (result.count == '0 && result.data == '0))
        else $error("empty status with queue not empty");

    // The count never exceeds the ring depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.count <= COUNT_W'(DEPTH)))
        else $error("count beyond depth");

endmodule
